FILE: src/ntt_pkg.sv
// Shared widths, codes and reset values of the number theoretic transform.
package ntt_pkg;

	localparam int VAL_W     = 31;
	localparam int IDX_W     = 10;
	localparam int OP_W      = 2;
	localparam int LOGP_W    = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG_POINTS = 2'd2;

	localparam logic [VAL_W-1:0]  MODULUS_RESET    = 31'd167772161;
	localparam logic [LOGP_W-1:0] LOG_POINTS_RESET = 4'd10;
	localparam logic [VAL_W-1:0]  GENERATOR        = 31'd3;
	localparam logic [VAL_W-1:0]  MIN_MODULUS      = 31'd3;

endpackage

FILE: src/ntt_if.sv
// Handshake interfaces for the command and reply channels.
interface ntt_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [ntt_pkg::OP_W-1:0]      operation;
	logic [ntt_pkg::VAL_W-1:0]     value;
	logic [ntt_pkg::IDX_W-1:0]     index;

	modport source (output valid, operation, value, index, input ready);
	modport sink (input valid, operation, value, index, output ready);
endinterface

interface ntt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ntt_pkg::VAL_W-1:0]     point;
	logic [ntt_pkg::IDX_W-1:0]     position;

	modport source (output valid, point, position, input ready);
	modport sink (input valid, point, position, output ready);
endinterface

FILE: src/number_theoretic_transform.sv
// Radix-2 number theoretic transform over a point store, driven by requests.
//
// Requests arrive on the command channel (valid/ready): load writes a value,
// reduced modulo the prime, at an index; run transforms the first
// N = 2^log_points points in place; read returns the point at an index on the
// reply channel together with the index as position. Configuration (modulus,
// direction, log_points) is written through cfg_write/cfg_index/cfg_data;
// the user must do so only while no request is in progress, which the block
// itself does not enforce. One request is handled at a time; ready is low
// until it is finished. Every modular product goes through one bit-serial
// multiplier. A load passes its value through the multiplier; a read waits
// while the reply register is still full. A run first reduces the points,
// then swaps the bit-reversed pairs, then in each of the log2 N stages
// computes the stage twiddle and does N/2 butterflies, with one more product
// per twiddle update; for the inverse direction it then scales every point by
// the inverse of N. Reset restores the configuration defaults and empties the
// reply register; the point store is not cleared. When the receiver stalls, a
// read holds its reply in the output register and a further read waits until
// it is taken; other requests are still accepted.
module number_theoretic_transform #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [ntt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ntt_pkg::VAL_W-1:0]     cfg_data,
	ntt_cmd_if.sink                       command,
	ntt_rsp_if.source                     reply
);

	localparam int VW = ntt_pkg::VAL_W;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int LW = $clog2(AW + 1);
	localparam int CW = AW + 1;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_LOAD     = 5'd1;
	localparam logic [4:0] S_READ     = 5'd2;
	localparam logic [4:0] S_RED_RD   = 5'd3;
	localparam logic [4:0] S_RED_MUL  = 5'd4;
	localparam logic [4:0] S_RED_WAIT = 5'd5;
	localparam logic [4:0] S_REV_CHK  = 5'd6;
	localparam logic [4:0] S_REV_RD2  = 5'd7;
	localparam logic [4:0] S_REV_WR1  = 5'd8;
	localparam logic [4:0] S_REV_WR2  = 5'd9;
	localparam logic [4:0] S_STG      = 5'd10;
	localparam logic [4:0] S_POW_SQ   = 5'd11;
	localparam logic [4:0] S_POW_SQW  = 5'd12;
	localparam logic [4:0] S_POW_ML   = 5'd13;
	localparam logic [4:0] S_POW_MLW  = 5'd14;
	localparam logic [4:0] S_POW_NX   = 5'd15;
	localparam logic [4:0] S_BF_RD    = 5'd16;
	localparam logic [4:0] S_BF_RD2   = 5'd17;
	localparam logic [4:0] S_BF_WAIT  = 5'd18;
	localparam logic [4:0] S_BF_WR2   = 5'd19;
	localparam logic [4:0] S_TW       = 5'd20;
	localparam logic [4:0] S_TWW      = 5'd21;
	localparam logic [4:0] S_SC_RD    = 5'd22;
	localparam logic [4:0] S_SC_MUL   = 5'd23;
	localparam logic [4:0] S_SC_WAIT  = 5'd24;

	localparam logic [VW-1:0] ONE = VW'(1);

	logic [4:0]                    state_q;
	logic [VW-1:0]                 modulus_q;
	logic                          inverse_q;
	logic [ntt_pkg::LOGP_W-1:0]    log_q;

	logic [AW-1:0]                 idx_q;
	logic [CW-1:0]                 j_q;
	logic [CW-1:0]                 pos_q;
	logic [CW-1:0]                 x_q;
	logic [LW-1:0]                 st_q;
	logic [4:0]                    bit_q;
	logic [VW-1:0]                 ex_q;
	logic [VW-1:0]                 pow_q;
	logic [VW-1:0]                 step_q;
	logic [VW-1:0]                 w_q;
	logic [VW-1:0]                 tmp_q;
	logic                          out_valid_q;
	logic [VW-1:0]                 point_q;
	logic [ntt_pkg::IDX_W-1:0]     position_q;

	logic [VW-1:0]   p_eff;
	logic [VW-1:0]   pm1;
	logic [VW-1:0]   base;
	logic [VW-1:0]   ninv;
	logic [VW-1:0]   ex_fwd;
	logic [LW-1:0]   lg;
	logic [CW-1:0]   n;
	logic [CW-1:0]   half;
	logic [CW-1:0]   span;
	logic [CW-1:0]   pos_next;
	logic [AW-1:0]   rev_full;
	logic [AW-1:0]   rev;
	logic [AW-1:0]   cmd_idx;
	logic            accept;
	logic            out_free;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [VW-1:0]   ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [VW-1:0]   ram_rdata;

	logic            mm_start;
	logic [VW-1:0]   mm_a;
	logic [VW-1:0]   mm_b;
	logic            mm_done;
	logic [VW-1:0]   mm_res;

	logic [VW:0]     bf_sum;
	logic [VW-1:0]   bf_hi;
	logic [VW-1:0]   bf_lo;

	assign p_eff   = (modulus_q < ntt_pkg::MIN_MODULUS) ? ntt_pkg::MIN_MODULUS : modulus_q;
	assign pm1     = p_eff - ONE;
	assign base    = (p_eff == ntt_pkg::MIN_MODULUS) ? '0 : ntt_pkg::GENERATOR;
	assign lg      = (32'(log_q) > AW) ? LW'(AW) : LW'(log_q);
	assign n       = CW'(1) << lg;
	assign half    = CW'(1) << st_q;
	assign span    = half << 1;
	assign pos_next = pos_q + span;
	// N * (p-1)/N is -1 modulo p, so p - (p-1)/N is the inverse of N.
	assign ninv    = p_eff - (pm1 >> lg);
	assign ex_fwd  = pm1 >> ((LW + 1)'(st_q) + (LW + 1)'(1));
	assign cmd_idx = AW'(command.index);
	assign accept  = command.valid && command.ready;
	assign out_free = !out_valid_q || reply.ready;

	always_comb begin
		for (int i = 0; i < AW; i++) begin
			rev_full[i] = j_q[AW-1-i];
		end
		rev = rev_full >> ((LW + 1)'(AW) - (LW + 1)'(lg));
	end

	// Butterfly on the low point (read data) and the twiddled high point.
	always_comb begin
		bf_sum = {1'b0, ram_rdata} + {1'b0, mm_res};
		bf_lo  = (bf_sum >= {1'b0, p_eff}) ? VW'(bf_sum - {1'b0, p_eff}) : VW'(bf_sum);
		if (ram_rdata >= mm_res) begin
			bf_hi = ram_rdata - mm_res;
		end else begin
			bf_hi = VW'({1'b0, ram_rdata} + {1'b0, p_eff} - {1'b0, mm_res});
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = j_q[AW-1:0];
		ram_wdata = mm_res;
		ram_re    = 1'b0;
		ram_raddr = j_q[AW-1:0];
		mm_start  = 1'b0;
		mm_a      = ONE;
		mm_b      = ram_rdata;
		case (state_q)
			S_IDLE: begin
				ram_raddr = cmd_idx;
				ram_re    = accept && (command.operation == ntt_pkg::OP_READ);
				mm_start  = accept && (command.operation == ntt_pkg::OP_LOAD);
				mm_b      = command.value;
			end
			S_LOAD: begin
				ram_we    = mm_done;
				ram_waddr = idx_q;
			end
			S_RED_RD: ram_re = 1'b1;
			S_RED_MUL: mm_start = 1'b1;
			S_RED_WAIT: ram_we = mm_done;
			S_REV_CHK: ram_re = (j_q != n) && (j_q < CW'(rev));
			S_REV_RD2: begin
				ram_re    = 1'b1;
				ram_raddr = rev;
			end
			S_REV_WR1: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			S_REV_WR2: begin
				ram_we    = 1'b1;
				ram_waddr = rev;
				ram_wdata = tmp_q;
			end
			S_POW_SQ: begin
				mm_start = 1'b1;
				mm_a     = pow_q;
				mm_b     = pow_q;
			end
			S_POW_ML: begin
				mm_start = ex_q[bit_q];
				mm_a     = base;
				mm_b     = pow_q;
			end
			S_BF_RD: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(pos_q + half);
			end
			S_BF_RD2: begin
				mm_start  = 1'b1;
				mm_a      = w_q;
				ram_re    = 1'b1;
				ram_raddr = pos_q[AW-1:0];
			end
			S_BF_WAIT: begin
				ram_we    = mm_done;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = bf_lo;
			end
			S_BF_WR2: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(pos_q + half);
				ram_wdata = tmp_q;
			end
			S_TW: begin
				mm_start = 1'b1;
				mm_a     = step_q;
				mm_b     = w_q;
			end
			S_SC_RD: ram_re = 1'b1;
			S_SC_MUL: begin
				mm_start = 1'b1;
				mm_a     = ninv;
			end
			S_SC_WAIT: ram_we = mm_done;
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= ntt_pkg::MODULUS_RESET;
			inverse_q <= 1'b0;
			log_q     <= ntt_pkg::LOG_POINTS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				ntt_pkg::CFG_MODULUS:    modulus_q <= cfg_data;
				ntt_pkg::CFG_INVERSE:    inverse_q <= cfg_data[0];
				ntt_pkg::CFG_LOG_POINTS: log_q <= cfg_data[ntt_pkg::LOGP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			j_q         <= '0;
			pos_q       <= '0;
			x_q         <= '0;
			st_q        <= '0;
			bit_q       <= '0;
		end else begin
			if (state_q == S_READ && out_free) begin
				out_valid_q <= 1'b1;
			end else if (reply.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (command.operation)
							ntt_pkg::OP_LOAD: state_q <= S_LOAD;
							ntt_pkg::OP_RUN: begin
								j_q     <= '0;
								state_q <= S_RED_RD;
							end
							ntt_pkg::OP_READ: state_q <= S_READ;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LOAD: if (mm_done) state_q <= S_IDLE;
				S_READ: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RED_RD: state_q <= S_RED_MUL;
				S_RED_MUL: state_q <= S_RED_WAIT;
				S_RED_WAIT: begin
					if (mm_done) begin
						if (j_q + CW'(1) == n) begin
							j_q     <= '0;
							state_q <= S_REV_CHK;
						end else begin
							j_q     <= j_q + CW'(1);
							state_q <= S_RED_RD;
						end
					end
				end
				S_REV_CHK: begin
					if (j_q == n) begin
						st_q <= '0;
						if (lg == '0) begin
							j_q     <= '0;
							state_q <= inverse_q ? S_SC_RD : S_IDLE;
						end else begin
							state_q <= S_STG;
						end
					end else if (j_q < CW'(rev)) begin
						state_q <= S_REV_RD2;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_REV_RD2: state_q <= S_REV_WR1;
				S_REV_WR1: state_q <= S_REV_WR2;
				S_REV_WR2: begin
					j_q     <= j_q + CW'(1);
					state_q <= S_REV_CHK;
				end
				S_STG: begin
					bit_q   <= 5'(VW - 1);
					state_q <= S_POW_SQ;
				end
				S_POW_SQ: state_q <= S_POW_SQW;
				S_POW_SQW: if (mm_done) state_q <= S_POW_ML;
				S_POW_ML: state_q <= ex_q[bit_q] ? S_POW_MLW : S_POW_NX;
				S_POW_MLW: if (mm_done) state_q <= S_POW_NX;
				S_POW_NX: begin
					if (bit_q == '0) begin
						x_q     <= '0;
						pos_q   <= '0;
						state_q <= S_BF_RD;
					end else begin
						bit_q   <= bit_q - 5'd1;
						state_q <= S_POW_SQ;
					end
				end
				S_BF_RD: state_q <= S_BF_RD2;
				S_BF_RD2: state_q <= S_BF_WAIT;
				S_BF_WAIT: if (mm_done) state_q <= S_BF_WR2;
				S_BF_WR2: begin
					if (pos_next < n) begin
						pos_q   <= pos_next;
						state_q <= S_BF_RD;
					end else if (x_q + CW'(1) == half) begin
						if (st_q == lg - LW'(1)) begin
							j_q     <= '0;
							state_q <= inverse_q ? S_SC_RD : S_IDLE;
						end else begin
							st_q    <= st_q + LW'(1);
							state_q <= S_STG;
						end
					end else begin
						x_q     <= x_q + CW'(1);
						pos_q   <= x_q + CW'(1);
						state_q <= S_TW;
					end
				end
				S_TW: state_q <= S_TWW;
				S_TWW: if (mm_done) state_q <= S_BF_RD;
				S_SC_RD: state_q <= S_SC_MUL;
				S_SC_MUL: state_q <= S_SC_WAIT;
				S_SC_WAIT: begin
					if (mm_done) begin
						j_q <= j_q + CW'(1);
						state_q <= (j_q + CW'(1) == n) ? S_IDLE : S_SC_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			idx_q <= cmd_idx;
		end
		// The reply payload only changes when the output register is free.
		if (state_q == S_READ && out_free) begin
			point_q    <= ram_rdata;
			position_q <= ntt_pkg::IDX_W'(idx_q);
		end
		if (state_q == S_REV_RD2) begin
			tmp_q <= ram_rdata;
		end
		if (state_q == S_BF_WAIT && mm_done) begin
			tmp_q <= bf_hi;
		end
		if (state_q == S_STG) begin
			// The inverse root raised to k is the root raised to p-1-k.
			ex_q  <= inverse_q ? pm1 - ex_fwd : ex_fwd;
			pow_q <= ONE;
		end
		if ((state_q == S_POW_SQW || state_q == S_POW_MLW) && mm_done) begin
			pow_q <= mm_res;
		end
		if (state_q == S_POW_NX && bit_q == '0) begin
			step_q <= pow_q;
			w_q    <= ONE;
		end
		if (state_q == S_TWW && mm_done) begin
			w_q <= mm_res;
		end
	end

	ntt_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_POINTS)
	) u_points (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ntt_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.p      (p_eff),
		.done   (mm_done),
		.res    (mm_res)
	);

	assign command.ready  = (state_q == S_IDLE);
	assign reply.valid    = out_valid_q;
	assign reply.point    = point_q;
	assign reply.position = position_q;

endmodule

FILE: src/ntt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ntt_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/ntt_mulmod.sv
// Bit-serial modular multiplier: res = a * b mod p, one bit of b per cycle.
module ntt_mulmod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ntt_pkg::VAL_W-1:0] a,
	input  logic [ntt_pkg::VAL_W-1:0] b,
	input  logic [ntt_pkg::VAL_W-1:0] p,
	output logic                      done,
	output logic [ntt_pkg::VAL_W-1:0] res
);

	localparam int VW = ntt_pkg::VAL_W;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [VW-1:0]     a_q;
	logic [VW-1:0]     b_q;
	logic [VW-1:0]     p_q;
	logic [VW:0]       p2_q;
	logic [VW-1:0]     r_q;
	logic [VW+1:0]     t;
	logic [VW+1:0]     t_p;
	logic [VW+1:0]     t_2p;
	logic [VW-1:0]     r_next;

	// The running remainder stays below p, so 2r + a is below 3p and one of
	// three candidates is the reduced value.
	always_comb begin
		t    = {1'b0, r_q, 1'b0} + (b_q[VW-1] ? {2'b00, a_q} : '0);
		t_p  = t - {2'b00, p_q};
		t_2p = t - {1'b0, p2_q};
		if (t >= {1'b0, p2_q}) begin
			r_next = VW'(t_2p);
		end else if (t >= {2'b00, p_q}) begin
			r_next = VW'(t_p);
		end else begin
			r_next = VW'(t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(VW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			p_q  <= p;
			p2_q <= {p, 1'b0};
			r_q  <= '0;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[VW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

FILE: tb/tb_number_theoretic_transform.sv
// Self-checking testbench of the number theoretic transform with scoreboard and drivers.
`timescale 1ns / 1ps

module tb_number_theoretic_transform;

	localparam int VW         = ntt_pkg::VAL_W;
	localparam int IW         = ntt_pkg::IDX_W;
	localparam int OW         = ntt_pkg::OP_W;
	localparam int LGW        = ntt_pkg::LOGP_W;
	localparam int CIW        = ntt_pkg::CFG_IDX_W;
	localparam int NPTS       = 1024;
	localparam int IDLE_LIMIT = 250000;
	localparam int SETTLE     = 200;

	typedef struct packed {
		logic [VW-1:0] point;
		logic [IW-1:0] position;
	} reply_t;

	// Predicts the point store and holds the replies that reads should produce.
	class ntt_scoreboard;
		logic [VW-1:0]     store [NPTS];
		bit                written [NPTS];
		longint unsigned   prime;
		bit                inv_dir;
		int unsigned       log_n;
		reply_t            replies_due [$];
		int unsigned       mismatches;
		int unsigned       unexpected;
		int unsigned       reads_seen;
		int unsigned       runs_seen;

		function new();
			prime = 64'(ntt_pkg::MODULUS_RESET);
			inv_dir = 1'b0;
			log_n = 32'(ntt_pkg::LOG_POINTS_RESET);
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		function longint unsigned eff_prime();
			return (prime < 64'(ntt_pkg::MIN_MODULUS)) ? 64'(ntt_pkg::MIN_MODULUS) : prime;
		endfunction

		function int unsigned eff_log();
			return (log_n > 10) ? 10 : log_n;
		endfunction

		function longint unsigned pow_mod(longint unsigned b, longint unsigned e,
				longint unsigned p);
			longint unsigned r;
			r = 64'(1) % p;
			b = b % p;
			while (e != 0) begin
				if (e & 1) r = r * b % p;
				b = b * b % p;
				e = e >> 1;
			end
			return r;
		endfunction

		function longint unsigned inv_mod(longint unsigned a, longint unsigned p);
			longint r0, r1, x0, x1, q, t;
			r0 = longint'(p);
			r1 = longint'(a % p);
			x0 = 0;
			x1 = 1;
			if (r1 == 0) return 0;
			while (r1 != 0) begin
				q = r0 / r1;
				t = r0 - q * r1; r0 = r1; r1 = t;
				t = x0 - q * x1; x0 = x1; x1 = t;
			end
			t = x0 % longint'(p);
			if (t < 0) t += longint'(p);
			return 64'(t);
		endfunction

		function void configure(logic [CIW-1:0] idx, logic [VW-1:0] data);
			case (idx)
				ntt_pkg::CFG_MODULUS:    prime = 64'(data);
				ntt_pkg::CFG_INVERSE:    inv_dir = data[0];
				ntt_pkg::CFG_LOG_POINTS: log_n = 32'(data[LGW-1:0]);
				default: ;
			endcase
		endfunction

		function void transform();
			longint unsigned p, n, h, stp, w, u, d, sum, ninv;
			int unsigned lg, r, half;
			logic [VW-1:0] tmp;
			p = eff_prime();
			lg = eff_log();
			n = 64'(1) << lg;
			for (int j = 0; j < n; j++) store[j] = VW'(64'(store[j]) % p);
			for (int j = 0; j < n; j++) begin
				r = 0;
				for (int b = 0; b < lg; b++)
					if ((j >> b) & 1) r |= 1 << (lg - 1 - b);
				if (j < r) begin
					tmp = store[j];
					store[j] = store[r];
					store[r] = tmp;
				end
			end
			h = pow_mod(64'(ntt_pkg::GENERATOR), (p - 1) / n, p);
			if (inv_dir) h = inv_mod(h, p);
			for (half = 1; half < n; half = half << 1) begin
				stp = pow_mod(h, n / (2 * half), p);
				w = 64'(1) % p;
				for (int x = 0; x < half; x++) begin
					for (int s = x; s < n; s += 2 * half) begin
						u = 64'(store[s]);
						d = 64'(store[s + half]) * w % p;
						sum = u + d;
						if (sum >= p) sum -= p;
						store[s] = VW'(sum);
						store[s + half] = VW'((u >= d) ? u - d : u + p - d);
					end
					w = w * stp % p;
				end
			end
			if (inv_dir) begin
				ninv = inv_mod(n % p, p);
				for (int j = 0; j < n; j++) store[j] = VW'(64'(store[j]) * ninv % p);
			end
		endfunction

		function void note_command(logic [OW-1:0] op, logic [VW-1:0] val,
				logic [IW-1:0] idx);
			reply_t rp;
			case (op)
				ntt_pkg::OP_LOAD: begin
					store[idx] = VW'(64'(val) % eff_prime());
					written[idx] = 1'b1;
				end
				ntt_pkg::OP_RUN: begin
					transform();
					runs_seen++;
				end
				ntt_pkg::OP_READ: begin
					rp.point = store[idx];
					rp.position = idx;
					replies_due.push_back(rp);
				end
				default: ;
			endcase
		endfunction

		function void check_reply(logic [VW-1:0] point, logic [IW-1:0] position);
			reply_t exp_r;
			reads_seen++;
			if (replies_due.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("unexpected reply: point %0d position %0d", point, position);
				return;
			end
			exp_r = replies_due.pop_front();
			if (exp_r.point !== point || exp_r.position !== position) begin
				mismatches++;
				if (mismatches + unexpected <= 10)
					$display("reply mismatch: expected point %0d position %0d, got %0d %0d",
						exp_r.point, exp_r.position, point, position);
			end
		endfunction

		function int unsigned pending();
			return replies_due.size();
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           cfg_write;
	logic [CIW-1:0] cfg_index;
	logic [VW-1:0]  cfg_data;

	ntt_cmd_if cmd_ch ();
	ntt_rsp_if rsp_ch ();

	number_theoretic_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.command   (cmd_ch.sink),
		.reply     (rsp_ch.source)
	);

	ntt_scoreboard sb = new();

	int unsigned idle_cycles;
	int unsigned burst_left;
	int unsigned requests_sent;
	int unsigned hold_request;
	bit          draining;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = ntt_pkg::CFG_MODULUS;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = ntt_pkg::OP_LOAD;
		cmd_ch.value = '0;
		cmd_ch.index = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Receiver: a stall pattern chosen at random for each window, plus a long hold on request.
	initial begin
		int unsigned mode, win, hold;
		mode = 0;
		win = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold = hold_request;
				hold_request = 0;
			end
			if (win == 0) begin
				mode = $urandom_range(0, 3);
				win = 64;
			end
			win--;
			if (hold != 0) begin
				hold--;
				rsp_ch.ready = 1'b0;
			end else if (draining || mode == 0)
				rsp_ch.ready = 1'b1;
			else if (mode == 1)
				rsp_ch.ready = 1'($urandom_range(0, 1));
			else if (mode == 2)
				rsp_ch.ready = ($urandom_range(0, 3) == 0);
			else
				rsp_ch.ready = ($urandom_range(0, 7) != 0);
		end
	end

	// Sample replies and watch for a block that has stopped moving.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (rsp_ch.valid && rsp_ch.ready) sb.check_reply(rsp_ch.point, rsp_ch.position);
				if ((rsp_ch.valid && rsp_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
					idle_cycles = 0;
				else
					idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("watchdog: no handshake for %0d cycles", idle_cycles);
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	// Offer one request and hold it until the block accepts it; gaps come between bursts.
	task automatic send(logic [OW-1:0] op, logic [VW-1:0] val, logic [IW-1:0] idx);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				cmd_ch.valid = 1'b0;
				cmd_ch.operation = OW'($urandom_range(0, 3));
				cmd_ch.value = VW'($urandom());
				cmd_ch.index = IW'($urandom());
			end
		end
		burst_left--;
		@(negedge clk);
		cmd_ch.valid = 1'b1;
		cmd_ch.operation = op;
		cmd_ch.value = val;
		cmd_ch.index = idx;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_command(op, val, idx);
		if (op != ntt_pkg::OP_NOP) requests_sent++;
	endtask

	// Let every reply come back and the block settle before touching the registers.
	task automatic quiesce();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIW-1:0] idx, logic [VW-1:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_write = 1'b0;
		cfg_data = VW'($urandom());
		sb.configure(idx, data);
	endtask

	task automatic setup(logic [VW-1:0] p, bit inv, logic [LGW-1:0] lg);
		quiesce();
		write_reg(ntt_pkg::CFG_MODULUS, p);
		write_reg(ntt_pkg::CFG_INVERSE, VW'(inv));
		write_reg(ntt_pkg::CFG_LOG_POINTS, VW'(lg));
	endtask

	function automatic logic [VW-1:0] pick_value(longint unsigned p);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return {VW{1'b1}};
			2: return VW'(p - 1);
			3: return VW'(p);
			default: return VW'($urandom());
		endcase
	endfunction

	function automatic logic [IW-1:0] pick_written(int unsigned n);
		logic [IW-1:0] i;
		if ($urandom_range(0, 5) == 0) begin
			do i = IW'($urandom()); while (!sb.written[i]);
			return i;
		end
		return IW'($urandom_range(0, n - 1));
	endfunction

	// A well-formed pass: fill the N points, mix loads, reads, runs and no-ops, transform, read back.
	task automatic random_pass(int unsigned extra, bit hold);
		int unsigned n, k;
		longint unsigned p;
		int unsigned order [$];
		p = sb.eff_prime();
		n = 1 << sb.eff_log();
		for (int j = 0; j < n; j++) order.push_back(j);
		order.shuffle();
		foreach (order[j]) send(ntt_pkg::OP_LOAD, pick_value(p), IW'(order[j]));
		for (int j = 0; j < extra; j++) begin
			k = $urandom_range(0, 9);
			if (k < 3)
				send(ntt_pkg::OP_LOAD, pick_value(p), IW'($urandom_range(0, n - 1)));
			else if (k < 4) send(ntt_pkg::OP_LOAD, pick_value(p), IW'($urandom()));
			else if (k < 5) send(ntt_pkg::OP_NOP, VW'($urandom()), IW'($urandom()));
			else if (k < 6) send(ntt_pkg::OP_RUN, VW'($urandom()), IW'($urandom()));
			else send(ntt_pkg::OP_READ, VW'($urandom()), pick_written(n));
		end
		send(ntt_pkg::OP_RUN, VW'($urandom()), IW'($urandom()));
		for (int j = 0; j < n && j < 12; j++) begin
			send(ntt_pkg::OP_READ, VW'($urandom()), pick_written(n));
			// Hold the receiver off while the read-back requests keep coming.
			if (hold && j == 0) hold_request = 400;
		end
		send(ntt_pkg::OP_READ, VW'($urandom()), '0);
	endtask

	typedef struct {
		logic [VW-1:0]  p;
		bit             inv;
		logic [LGW-1:0] lg;
	} setting_t;

	initial begin
		setting_t plan [10];
		int unsigned pass_no;
		burst_left = 0;
		requests_sent = 0;
		hold_request = 0;
		draining = 1'b0;
		plan[0] = '{31'd998244353, 1'b0, 4'd3};
		plan[1] = '{31'd998244353, 1'b1, 4'd3};
		plan[2] = '{31'd17, 1'b1, 4'd4};
		plan[3] = '{31'd5, 1'b0, 4'd2};
		plan[4] = '{31'd7, 1'b1, 4'd1};
		plan[5] = '{31'd2147483647, 1'b0, 4'd1};
		plan[6] = '{31'd469762049, 1'b1, 4'd5};
		plan[7] = '{31'd167772161, 1'b0, 4'd6};
		plan[8] = '{31'd998244353, 1'b0, 4'd0};
		plan[9] = '{31'd17, 1'b0, 4'd4};
		wait (arst_n === 1'b1);
		repeat (4) @(posedge clk);

		// Directed: field extremes, every operation, entries beyond N, a stale modulus.
		setup(31'd5, 1'b0, 4'd2);
		send(ntt_pkg::OP_LOAD, {VW{1'b1}}, IW'(0));
		send(ntt_pkg::OP_LOAD, '0, IW'(1));
		send(ntt_pkg::OP_LOAD, 31'd4, IW'(2));
		send(ntt_pkg::OP_LOAD, 31'd7, IW'(3));
		send(ntt_pkg::OP_READ, '0, IW'(3));
		send(ntt_pkg::OP_LOAD, 31'd12345, {IW{1'b1}});
		send(ntt_pkg::OP_READ, {VW{1'b1}}, {IW{1'b1}});
		send(ntt_pkg::OP_RUN, '0, '0);
		for (int j = 0; j < 4; j++) send(ntt_pkg::OP_READ, '0, IW'(j));
		send(ntt_pkg::OP_NOP, {VW{1'b1}}, {IW{1'b1}});
		setup(31'd5, 1'b1, 4'd2);
		send(ntt_pkg::OP_RUN, '0, '0);
		send(ntt_pkg::OP_READ, '0, IW'(0));
		send(ntt_pkg::OP_READ, '0, IW'(2));
		// The old residues modulo five are reduced again under the new modulus.
		setup(31'd7, 1'b0, 4'd1);
		send(ntt_pkg::OP_RUN, '0, '0);
		send(ntt_pkg::OP_READ, '0, IW'(0));
		send(ntt_pkg::OP_READ, '0, IW'(1));
		send(ntt_pkg::OP_READ, '0, {IW{1'b1}});

		// Random passes, with one long receiver hold while reads keep coming.
		pass_no = 0;
		while (requests_sent < 400) begin
			setup(plan[pass_no % 10].p, plan[pass_no % 10].inv, plan[pass_no % 10].lg);
			random_pass($urandom_range(10, 40), pass_no == 2);
			pass_no++;
		end

		quiesce();
		draining = 1'b1;
		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d requests, %0d transforms and %0d replies in %0d random passes.",
			requests_sent, sb.runs_seen, sb.reads_seen, pass_no);
		$display("Moduli from 5 to 2^31-1, both directions, 1 to 64 points, one long stall.");
		if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else begin
			$display("%0d mismatches, %0d unexpected, %0d missing replies",
				sb.mismatches, sb.unexpected, sb.pending());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
